FILE: rtl/core/rdir_pkg.sv
// Package for the refraction direction core: field widths, default
// fraction width and constant helpers. No dependencies.
package rdir_pkg;

  localparam int COMP_W        = 16;
  localparam int IOR_W         = 15;
  localparam int FRAC_BITS_DEF = 14;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/core/refract_direction_core.sv
// Snell's-law refraction of a direction vector in Q(16-FRAC_BITS).FRAC_BITS.
// Pipeline depth grows with FRAC_BITS and SQN, set by the bit-per-stage
// reciprocal of the index and the bit-per-stage square root.
// Throughput: one transaction per cycle; the whole pipe holds on out stall while out_valid.
// Reset: synchronous, active low; clears all stage valid bits.
// Depends on rdir_pkg.
module refract_direction_core #(
  parameter int FRAC_BITS = rdir_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [rdir_pkg::COMP_W-1:0] in_inc_x,
  input  logic signed [rdir_pkg::COMP_W-1:0] in_inc_y,
  input  logic signed [rdir_pkg::COMP_W-1:0] in_inc_z,
  input  logic signed [rdir_pkg::COMP_W-1:0] in_nrm_x,
  input  logic signed [rdir_pkg::COMP_W-1:0] in_nrm_y,
  input  logic signed [rdir_pkg::COMP_W-1:0] in_nrm_z,
  input  logic        [rdir_pkg::IOR_W-1:0]  in_ior,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rdir_pkg::COMP_W-1:0] out_x,
  output logic signed [rdir_pkg::COMP_W-1:0] out_y,
  output logic signed [rdir_pkg::COMP_W-1:0] out_z,
  output logic                             out_total_reflect
);

  localparam int F    = FRAC_BITS;
  localparam int CPW  = rdir_pkg::COMP_W;
  localparam int RW   = rdir_pkg::max2(rdir_pkg::IOR_W, F);
  localparam int NUMW = 2 * F;
  localparam int EW   = RW + 2;
  localparam int DW   = 2 * CPW + 3;
  localparam int CW   = rdir_pkg::max2(2 * CPW + 4 - F, 8);
  localparam int CCW  = rdir_pkg::max2(2 * CW, F + 2);
  localparam int EEW  = rdir_pkg::max2(2 * EW, F + 2);
  localparam int SW   = rdir_pkg::max2(2 * CW - F, F) + 2;
  localparam int E2W  = 2 * EW - F + 2;
  localparam int PKW  = rdir_pkg::max2(E2W + SW, F + 2);
  localparam int KW   = rdir_pkg::max2(E2W + SW - F, F) + 2;
  localparam int QW   = KW + F;
  localparam int QWE  = QW + (QW % 2);
  localparam int SQN  = QWE / 2;
  localparam int ECPW = rdir_pkg::max2(EW + 1 + CW, F + 2);
  localparam int ECW  = rdir_pkg::max2(ECPW - F + 1, 2);
  localparam int COW  = rdir_pkg::max2(ECW, SQN + 1) + 1;
  localparam int EIPW = rdir_pkg::max2(EW + 1 + CPW, F + 2);
  localparam int EIW  = rdir_pkg::max2(EIPW - F + 1, 2);
  localparam int DNPW = rdir_pkg::max2(CW + CPW, F + 2);
  localparam int DNW  = rdir_pkg::max2(DNPW - F + 1, 2);
  localparam int CNPW = rdir_pkg::max2(COW + CPW + 1, F + 2);
  localparam int CNW  = rdir_pkg::max2(CNPW - F + 1, 2);
  localparam int RESW = rdir_pkg::max2(rdir_pkg::max2(EIW, CNW),
                                       rdir_pkg::max2(DNW + 1, CPW + 1)) + 2;

  localparam int ST_D0 = 3;
  localparam int ST_E  = ST_D0 + F + 1;
  localparam int ST_G  = ST_E + 1;
  localparam int ST_H  = ST_G + 1;
  localparam int ST_I  = ST_H + 1;
  localparam int ST_S0 = ST_I + 1;
  localparam int ST_J  = ST_S0 + SQN;
  localparam int ST_K  = ST_J + 1;
  localparam int ST_L  = ST_K + 1;
  localparam int ST_M  = ST_L + 1;
  localparam int NS    = ST_M + 1;

  localparam logic [RW-1:0]          IOR_ONE = RW'(1) << (F - 1);
  localparam logic signed [RESW-1:0] SAT_HI  = RESW'(32767);
  localparam logic signed [RESW-1:0] SAT_LO  = -RESW'(32768);

  typedef struct {
    logic signed [CPW-1:0]   iv [3];
    logic signed [CPW-1:0]   nv [3];
    logic signed [CPW:0]     nn [3];
    logic [RW-1:0]           r;
    logic                    ent;
    logic                    tir;
    logic signed [2*CPW-1:0] pr [3];
    logic signed [DW-1:0]    dot;
    logic signed [CW-1:0]    c;
    logic signed [CW-1:0]    d;
    logic [NUMW-1:0]         num;
    logic [RW:0]             rem;
    logic [F:0]              q;
    logic [EW-1:0]           eta;
    logic signed [CCW-1:0]   cc;
    logic [EEW-1:0]          ee;
    logic signed [SW-1:0]    s2;
    logic signed [E2W-1:0]   e2;
    logic signed [PKW-1:0]   pk;
    logic signed [KW-1:0]    k;
    logic [QWE-1:0]          x;
    logic [SQN+2:0]          srem;
    logic [SQN-1:0]          sroot;
    logic signed [ECPW-1:0]  ec;
    logic signed [EIPW-1:0]  ei [3];
    logic signed [DNPW-1:0]  dn [3];
    logic signed [COW-1:0]   coef;
    logic signed [EIW-1:0]   eir [3];
    logic signed [DNW-1:0]   dnr [3];
    logic signed [CNPW-1:0]  cn [3];
    logic signed [CPW-1:0]   o [3];
  } pl_t;

  pl_t           p_r   [NS];
  pl_t           p_nxt [NS];
  logic [NS-1:0] v_r;
  logic          adv;

  assign adv      = !v_r[NS-1] || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    logic signed [DW:0]     ndot;
    logic signed [DW:0]     rnd_n;
    logic signed [DW-1:0]   rnd_d;
    logic [RW:0]            dv_t;
    logic signed [CCW-1:0]  rnd_cc;
    logic [EEW-1:0]         rnd_ee;
    logic signed [PKW-1:0]  rnd_pk;
    logic [SQN+2:0]         sq_sh;
    logic [SQN+2:0]         sq_cand;
    logic signed [ECPW-1:0] rnd_ec;
    logic signed [EIPW-1:0] rnd_ei;
    logic signed [DNPW-1:0] rnd_dn;
    logic signed [CNPW-1:0] rnd_cn;
    logic signed [RESW-1:0] res;

    p_nxt[0]       = p_r[0];
    p_nxt[0].iv[0] = in_inc_x;
    p_nxt[0].iv[1] = in_inc_y;
    p_nxt[0].iv[2] = in_inc_z;
    p_nxt[0].nv[0] = in_nrm_x;
    p_nxt[0].nv[1] = in_nrm_y;
    p_nxt[0].nv[2] = in_nrm_z;
    p_nxt[0].r     = RW'(in_ior);
    p_nxt[0].pr[0] = (2*CPW)'(in_inc_x) * (2*CPW)'(in_nrm_x);
    p_nxt[0].pr[1] = (2*CPW)'(in_inc_y) * (2*CPW)'(in_nrm_y);
    p_nxt[0].pr[2] = (2*CPW)'(in_inc_z) * (2*CPW)'(in_nrm_z);

    p_nxt[1]     = p_r[0];
    p_nxt[1].dot = DW'(p_r[0].pr[0]) + DW'(p_r[0].pr[1]) + DW'(p_r[0].pr[2]);
    p_nxt[1].ent = (DW'(p_r[0].pr[0]) + DW'(p_r[0].pr[1]) + DW'(p_r[0].pr[2])) < 0;
    p_nxt[1].r   = (p_r[0].r < IOR_ONE) ? IOR_ONE : p_r[0].r;

    p_nxt[2]     = p_r[1];
    ndot         = -((DW+1)'(p_r[1].dot));
    rnd_n        = (ndot + ((DW+1)'(1) <<< (F - 1))) >>> F;
    rnd_d        = (p_r[1].dot + (DW'(1) <<< (F - 1))) >>> F;
    p_nxt[2].d   = CW'(rnd_d);
    p_nxt[2].c   = p_r[1].ent ? CW'(rnd_n) : CW'(rnd_d);
    p_nxt[2].num = (NUMW'(1) << (2 * F - 1)) + NUMW'(p_r[1].r >> 1);
    p_nxt[2].rem = (RW+1)'(((NUMW'(1) << (2 * F - 1)) + NUMW'(p_r[1].r >> 1)) >> (F + 1));
    p_nxt[2].q   = '0;

    for (int i = 0; i <= F; i++) begin
      p_nxt[ST_D0+i] = p_r[ST_D0+i-1];
      dv_t = {p_r[ST_D0+i-1].rem[RW-1:0], p_r[ST_D0+i-1].num[F-i]};
      if (dv_t >= (RW+1)'(p_r[ST_D0+i-1].r)) begin
        p_nxt[ST_D0+i].rem = dv_t - (RW+1)'(p_r[ST_D0+i-1].r);
        p_nxt[ST_D0+i].q   = {p_r[ST_D0+i-1].q[F-1:0], 1'b1};
      end else begin
        p_nxt[ST_D0+i].rem = dv_t;
        p_nxt[ST_D0+i].q   = {p_r[ST_D0+i-1].q[F-1:0], 1'b0};
      end
    end

    p_nxt[ST_E]     = p_r[ST_E-1];
    p_nxt[ST_E].eta = p_r[ST_E-1].ent ? EW'(p_r[ST_E-1].q)
                                      : (EW'(p_r[ST_E-1].r) << 1);
    p_nxt[ST_E].cc  = CCW'(p_r[ST_E-1].c) * CCW'(p_r[ST_E-1].c);
    p_nxt[ST_E].ee  = p_r[ST_E-1].ent
                    ? EEW'(p_r[ST_E-1].q) * EEW'(p_r[ST_E-1].q)
                    : EEW'(EW'(p_r[ST_E-1].r) << 1) * EEW'(EW'(p_r[ST_E-1].r) << 1);

    p_nxt[ST_G]    = p_r[ST_E];
    rnd_cc         = (p_r[ST_E].cc + (CCW'(1) <<< (F - 1))) >>> F;
    rnd_ee         = (p_r[ST_E].ee + (EEW'(1) << (F - 1))) >> F;
    p_nxt[ST_G].s2 = (SW'(1) <<< F) - SW'(rnd_cc);
    p_nxt[ST_G].e2 = E2W'(rnd_ee);

    p_nxt[ST_H]    = p_r[ST_G];
    p_nxt[ST_H].pk = PKW'(p_r[ST_G].e2) * PKW'(p_r[ST_G].s2);

    p_nxt[ST_I]       = p_r[ST_H];
    rnd_pk            = (p_r[ST_H].pk + (PKW'(1) <<< (F - 1))) >>> F;
    p_nxt[ST_I].k     = (KW'(1) <<< F) - KW'(rnd_pk);
    p_nxt[ST_I].tir   = ((KW'(1) <<< F) - KW'(rnd_pk)) < 0;
    p_nxt[ST_I].x     = (((KW'(1) <<< F) - KW'(rnd_pk)) < 0) ? '0
                      : (QWE'(unsigned'((KW'(1) <<< F) - KW'(rnd_pk))) << F);
    p_nxt[ST_I].srem  = '0;
    p_nxt[ST_I].sroot = '0;

    for (int j = 0; j < SQN; j++) begin
      p_nxt[ST_S0+j] = p_r[ST_S0+j-1];
      sq_sh   = {p_r[ST_S0+j-1].srem[SQN:0], p_r[ST_S0+j-1].x[QWE-1-2*j -: 2]};
      sq_cand = (SQN+3)'({p_r[ST_S0+j-1].sroot, 2'b01});
      if (sq_sh >= sq_cand) begin
        p_nxt[ST_S0+j].srem  = sq_sh - sq_cand;
        p_nxt[ST_S0+j].sroot = {p_r[ST_S0+j-1].sroot[SQN-2:0], 1'b1};
      end else begin
        p_nxt[ST_S0+j].srem  = sq_sh;
        p_nxt[ST_S0+j].sroot = {p_r[ST_S0+j-1].sroot[SQN-2:0], 1'b0};
      end
    end

    p_nxt[ST_J]    = p_r[ST_J-1];
    p_nxt[ST_J].ec = ECPW'(signed'({1'b0, p_r[ST_J-1].eta})) * ECPW'(p_r[ST_J-1].c);
    for (int j = 0; j < 3; j++) begin
      p_nxt[ST_J].ei[j] = EIPW'(signed'({1'b0, p_r[ST_J-1].eta}))
                        * EIPW'(p_r[ST_J-1].iv[j]);
      p_nxt[ST_J].dn[j] = DNPW'(p_r[ST_J-1].d) * DNPW'(p_r[ST_J-1].nv[j]);
      p_nxt[ST_J].nn[j] = p_r[ST_J-1].ent ? (CPW+1)'(p_r[ST_J-1].nv[j])
                                          : -((CPW+1)'(p_r[ST_J-1].nv[j]));
    end

    p_nxt[ST_K]      = p_r[ST_J];
    rnd_ec           = (p_r[ST_J].ec + (ECPW'(1) <<< (F - 1))) >>> F;
    p_nxt[ST_K].coef = COW'(ECW'(rnd_ec)) - COW'(signed'({1'b0, p_r[ST_J].sroot}));
    for (int j = 0; j < 3; j++) begin
      rnd_ei             = (p_r[ST_J].ei[j] + (EIPW'(1) <<< (F - 1))) >>> F;
      rnd_dn             = (p_r[ST_J].dn[j] + (DNPW'(1) <<< (F - 1))) >>> F;
      p_nxt[ST_K].eir[j] = EIW'(rnd_ei);
      p_nxt[ST_K].dnr[j] = DNW'(rnd_dn);
    end

    p_nxt[ST_L] = p_r[ST_K];
    for (int j = 0; j < 3; j++) begin
      p_nxt[ST_L].cn[j] = CNPW'(p_r[ST_K].coef) * CNPW'(p_r[ST_K].nn[j]);
    end

    p_nxt[ST_M] = p_r[ST_L];
    for (int j = 0; j < 3; j++) begin
      rnd_cn = (p_r[ST_L].cn[j] + (CNPW'(1) <<< (F - 1))) >>> F;
      if (p_r[ST_L].tir) begin
        res = RESW'(p_r[ST_L].iv[j]) - (RESW'(p_r[ST_L].dnr[j]) <<< 1);
      end else begin
        res = RESW'(p_r[ST_L].eir[j]) + RESW'(CNW'(rnd_cn));
      end
      priority if (res > SAT_HI) begin
        p_nxt[ST_M].o[j] = CPW'(SAT_HI);
      end else if (res < SAT_LO) begin
        p_nxt[ST_M].o[j] = CPW'(SAT_LO);
      end else begin
        p_nxt[ST_M].o[j] = CPW'(res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NS; s++) begin
        p_r[s] <= p_nxt[s];
      end
    end
  end

  assign out_valid         = v_r[NS-1];
  assign out_x             = p_r[ST_M].o[0];
  assign out_y             = p_r[ST_M].o[1];
  assign out_z             = p_r[ST_M].o[2];
  assign out_total_reflect = p_r[ST_M].tir;

endmodule
